>>> hdl/audio_transport_clock_macros.svh
// Assertion macros shared by the transport clock checker.
// Stand-alone header; no other file is needed.
`ifndef AUDIO_TRANSPORT_CLOCK_MACROS_SVH
`define AUDIO_TRANSPORT_CLOCK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/atc_pkg.sv
// Shared widths, command codes, register indexes and reset values
// for the audio transport clock. No dependencies.
package atc_pkg;

   // Width of the internal sample counter and tick saturation point.
   localparam int POSITION_BITS = 48;

   // Fixed field widths.
   localparam int QW          = 48;
   localparam int CMD_W       = 3;
   localparam int NSAMP_W     = 16;
   localparam int RATE_W      = 19;
   localparam int BPM_W       = 10;
   localparam int TPQ_W       = 16;
   localparam int BPB_W       = 6;
   localparam int NOTE_W      = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 19;
   localparam int BAR_W       = 32;
   localparam int BEAT_W      = 6;

   // Datapath widths.
   localparam int TW      = (POSITION_BITS > QW) ? POSITION_BITS : QW;
   localparam int HALF_W  = (TW + 1) / 2;
   localparam int KW      = TPQ_W + BPM_W;       // ticks_per_quarter * tempo
   localparam int R60_W   = RATE_W + 6;          // sample_rate * 60
   localparam int SPBN_W  = R60_W + NOTE_W;      // samples-per-beat numerator
   localparam int SPB_W   = SPBN_W - 2;          // divided by at least 4
   localparam int DEN_W   = SPB_W + BPB_W;       // widest divisor (bar length)
   localparam int NUM_W   = TW + KW;             // widest dividend
   localparam int CNT_W   = $clog2(NUM_W + 1);

   localparam logic [R60_W-1:0]         SECONDS_PER_MIN = R60_W'(60);
   localparam logic [POSITION_BITS-1:0] POS_MAX         = '1;
   localparam logic [BAR_W-1:0]         BAR_MAX         = '1;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TPQ         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BEATS_BAR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_NOTE   = 3'd4;

   // Register reset values.
   localparam logic [RATE_W-1:0] RATE_RST = 19'd48000;
   localparam logic [BPM_W-1:0]  BPM_RST  = 10'd120;
   localparam logic [TPQ_W-1:0]  TPQ_RST  = 16'd480;
   localparam logic [BPB_W-1:0]  BPB_RST  = 6'd4;
   localparam logic [NOTE_W-1:0] NOTE_RST = 6'd4;

endpackage

>>> hdl/audio_transport_clock.sv
// Audio transport clock: sample counter, tick position, bar and beat. Needs atc_pkg, atc_div.
// A full conversion takes five passes of NUM_W steps through the shared divider; a zero
//   rate, tempo, resolution or note value skips them and goes straight to the output step.
// One command at a time; the next command enters once the result is in the
//   output register, even while that result waits.
// Reset: synchronous; counter and run flag clear, registers load defaults.
module audio_transport_clock (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_we,
   input  logic [atc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // command channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [atc_pkg::CMD_W-1:0]      req_command,
   input  logic [atc_pkg::NSAMP_W-1:0]    req_num_samples,
   input  logic [atc_pkg::QW-1:0]         req_query_ticks,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [atc_pkg::QW-1:0]         rsp_sample_position,
   output logic [atc_pkg::QW-1:0]         rsp_tick_position,
   output logic [atc_pkg::BAR_W-1:0]      rsp_bar_number,
   output logic [atc_pkg::BEAT_W-1:0]     rsp_beat_number,
   output logic                           rsp_is_running
);
   import atc_pkg::*;

   // Sequencer steps. Each *_WAIT step holds until the divider finishes.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TMUL_LO,    // low half of samples * (tpq * bpm)
      ST_TMUL_HI,    // high half, then divide by 60 * rate
      ST_TDIV_WAIT,  // ticks ready; start samples-per-beat division
      ST_SPB_WAIT,   // samples per beat ready
      ST_LEN,        // bar length = samples per beat * beats per bar
      ST_SMUL_LO,    // low half of ticks * (60 * rate)
      ST_SMUL_HI,    // high half, then divide by tpq * bpm
      ST_SDIV_WAIT,  // sample position of the ticks; divide by bar length
      ST_BDIV_WAIT,  // bar ready; divide remainder by samples per beat
      ST_BEAT_WAIT,  // beat ready
      ST_DONE        // hand the result to the output register
   } state_type;

   state_type state_ff;

   // configuration
   logic [RATE_W-1:0] cfg_rate_ff;
   logic [BPM_W-1:0]  cfg_bpm_ff;
   logic [TPQ_W-1:0]  cfg_tpq_ff;
   logic [BPB_W-1:0]  cfg_bpb_ff;
   logic [NOTE_W-1:0] cfg_note_ff;

   // transport state
   logic [POSITION_BITS-1:0] count_ff;
   logic                     run_ff;
   logic [POSITION_BITS-1:0] count_in;
   logic                     run_in;
   logic [POSITION_BITS:0]   count_sum;

   // per-command working registers
   logic [CMD_W-1:0]         cmd_ff;
   logic [QW-1:0]            query_ff;
   logic [KW-1:0]            k_ff;
   logic [R60_W-1:0]         r60_ff;
   logic [HALF_W+KW-1:0]     prod_ff;
   logic [TW-1:0]            tsrc_ff;
   logic [SPB_W-1:0]         spb_ff;
   logic [DEN_W-1:0]         len_ff;
   logic [POSITION_BITS-1:0] ticks_ff;
   logic [BAR_W-1:0]         bar_ff;
   logic [BEAT_W-1:0]        beat_ff;

   // divider hookup
   logic [NUM_W-1:0] div_num_ff;
   logic [DEN_W-1:0] div_den_ff;
   logic             div_go_ff;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;
   logic [DEN_W-1:0] div_rem;

   // output register
   logic              rsp_valid_ff;
   logic [QW-1:0]     rsp_sample_ff;
   logic [QW-1:0]     rsp_tick_ff;
   logic [BAR_W-1:0]  rsp_bar_ff;
   logic [BEAT_W-1:0] rsp_beat_ff;
   logic              rsp_run_ff;

   // combinational helpers
   logic                     settings_ok;
   logic [TW-1:0]            mul_src;
   logic [HALF_W-1:0]        mul_a;
   logic [KW-1:0]            mul_b;
   logic [HALF_W+KW-1:0]     mul_p;
   logic [NUM_W-1:0]         mul_acc;
   logic [SPBN_W-1:0]        spb_num;
   logic [DEN_W-1:0]         len_prod;
   logic [POSITION_BITS-1:0] ticks_sat;
   logic [BAR_W-1:0]         bar_in;

   atc_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // Any zero among rate, tempo, resolution and note value disables conversions.
   assign settings_ok = (cfg_rate_ff != '0) && (cfg_bpm_ff != '0) &&
                        (cfg_tpq_ff != '0) && (cfg_note_ff != '0);

   // Apply the command to the counter and run flag; the counter saturates.
   always_comb begin
      count_sum = {1'b0, count_ff} + (POSITION_BITS + 1)'(req_num_samples);
      count_in  = count_ff;
      run_in    = run_ff;
      case (req_command)
         CMD_ADVANCE: begin
            if (run_ff) begin
               count_in = count_sum[POSITION_BITS] ? POS_MAX : count_sum[POSITION_BITS-1:0];
            end
         end
         CMD_START: run_in   = 1'b1;
         CMD_STOP:  run_in   = 1'b0;
         CMD_CLEAR: count_in = '0;
         default:   ;
      endcase
   end

   // One half-width multiplier serves both wide products, low half first.
   always_comb begin
      mul_src = (state_ff inside {ST_TMUL_LO, ST_TMUL_HI}) ? TW'(count_ff) : tsrc_ff;
      mul_b   = (state_ff inside {ST_TMUL_LO, ST_TMUL_HI}) ? k_ff : KW'(r60_ff);
      mul_a   = (state_ff inside {ST_TMUL_HI, ST_SMUL_HI}) ? HALF_W'(mul_src >> HALF_W)
                                                            : mul_src[HALF_W-1:0];
      mul_p   = (HALF_W + KW)'(mul_a) * (HALF_W + KW)'(mul_b);
      mul_acc = NUM_W'(prod_ff) + (NUM_W'(mul_p) << HALF_W);
   end

   assign spb_num  = SPBN_W'(r60_ff) * SPBN_W'(cfg_note_ff);
   assign len_prod = DEN_W'(spb_ff) * DEN_W'(cfg_bpb_ff);

   // Ticks saturate at the top of the position range.
   assign ticks_sat = (|div_quo[NUM_W-1:POSITION_BITS]) ? POS_MAX
                                                        : div_quo[POSITION_BITS-1:0];

   // One-based bar, pinned at all ones.
   assign bar_in = ((|div_quo[NUM_W-1:BAR_W]) || (div_quo[BAR_W-1:0] == BAR_MAX)) ?
                   BAR_MAX : div_quo[BAR_W-1:0] + BAR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         count_ff     <= '0;
         run_ff       <= 1'b0;
         cfg_rate_ff  <= RATE_RST;
         cfg_bpm_ff   <= BPM_RST;
         cfg_tpq_ff   <= TPQ_RST;
         cfg_bpb_ff   <= BPB_RST;
         cfg_note_ff  <= NOTE_RST;
      end else begin
         div_go_ff <= 1'b0;

         // Register writes; unknown indexes drop.
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLE_RATE: cfg_rate_ff <= csr_wdata[RATE_W-1:0];
               CSR_TEMPO_BPM:   cfg_bpm_ff  <= csr_wdata[BPM_W-1:0];
               CSR_TPQ:         cfg_tpq_ff  <= csr_wdata[TPQ_W-1:0];
               CSR_BEATS_BAR:   cfg_bpb_ff  <= csr_wdata[BPB_W-1:0];
               CSR_BEAT_NOTE:   cfg_note_ff <= csr_wdata[NOTE_W-1:0];
               default:         ;
            endcase
         end

         // Release the output register once its beat is taken; the last step
         // reloads it on its own.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  count_ff <= count_in;
                  run_ff   <= run_in;
                  cmd_ff   <= req_command;
                  query_ff <= req_query_ticks;
                  k_ff     <= KW'(cfg_tpq_ff) * KW'(cfg_bpm_ff);
                  r60_ff   <= R60_W'(cfg_rate_ff) * SECONDS_PER_MIN;
                  state_ff <= ST_TMUL_LO;
               end
            end
            ST_TMUL_LO: begin
               if (!settings_ok) begin
                  // report zeros for ticks, bar and beat
                  ticks_ff <= '0;
                  bar_ff   <= '0;
                  beat_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  prod_ff  <= mul_p;
                  state_ff <= ST_TMUL_HI;
               end
            end
            ST_TMUL_HI: begin
               div_num_ff <= mul_acc;
               div_den_ff <= DEN_W'(r60_ff);
               div_go_ff  <= 1'b1;
               state_ff   <= ST_TDIV_WAIT;
            end
            ST_TDIV_WAIT: begin
               if (div_done) begin
                  ticks_ff   <= ticks_sat;
                  // a query converts its own ticks, everything else the current ones
                  tsrc_ff    <= (cmd_ff == CMD_QUERY) ? TW'(query_ff) : TW'(ticks_sat);
                  div_num_ff <= NUM_W'(spb_num);
                  div_den_ff <= DEN_W'(cfg_bpm_ff) << 2;  // tempo * 4
                  div_go_ff  <= 1'b1;
                  state_ff   <= ST_SPB_WAIT;
               end
            end
            ST_SPB_WAIT: begin
               if (div_done) begin
                  spb_ff <= div_quo[SPB_W-1:0];
                  if ((div_quo[SPB_W-1:0] == '0) || (cfg_bpb_ff == '0)) begin
                     // zero beat or bar length: no bar and beat
                     bar_ff   <= '0;
                     beat_ff  <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_LEN;
                  end
               end
            end
            ST_LEN: begin
               len_ff   <= len_prod;
               state_ff <= ST_SMUL_LO;
            end
            ST_SMUL_LO: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SMUL_HI;
            end
            ST_SMUL_HI: begin
               div_num_ff <= mul_acc;
               div_den_ff <= DEN_W'(k_ff);
               div_go_ff  <= 1'b1;
               state_ff   <= ST_SDIV_WAIT;
            end
            ST_SDIV_WAIT: begin
               if (div_done) begin
                  div_num_ff <= div_quo;
                  div_den_ff <= len_ff;
                  div_go_ff  <= 1'b1;
                  state_ff   <= ST_BDIV_WAIT;
               end
            end
            ST_BDIV_WAIT: begin
               if (div_done) begin
                  bar_ff     <= bar_in;
                  div_num_ff <= NUM_W'(div_rem);
                  div_den_ff <= DEN_W'(spb_ff);
                  div_go_ff  <= 1'b1;
                  state_ff   <= ST_BEAT_WAIT;
               end
            end
            ST_BEAT_WAIT: begin
               if (div_done) begin
                  beat_ff  <= div_quo[BEAT_W-1:0] + BEAT_W'(1);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= QW'(count_ff);
                  rsp_tick_ff   <= QW'(ticks_ff);
                  rsp_bar_ff    <= bar_ff;
                  rsp_beat_ff   <= beat_ff;
                  rsp_run_ff    <= run_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_position = rsp_sample_ff;
   assign rsp_tick_position   = rsp_tick_ff;
   assign rsp_bar_number      = rsp_bar_ff;
   assign rsp_beat_number     = rsp_beat_ff;
   assign rsp_is_running      = rsp_run_ff;

endmodule

>>> hdl/atc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all conversions.
// Depends on atc_pkg for dividend and divisor widths.
module atc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [atc_pkg::NUM_W-1:0]  num,
   input  logic [atc_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [atc_pkg::NUM_W-1:0]  quo,
   output logic [atc_pkg::DEN_W-1:0]  rem
);
   import atc_pkg::*;

   logic [NUM_W-1:0] n_ff;
   logic [DEN_W-1:0] r_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {r_ff, n_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            n_ff    <= num;
            r_ff    <= '0;
            den_ff  <= den;
            cnt_ff  <= CNT_W'(NUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // shift in the next dividend bit, subtract when it fits
            n_ff   <= {n_ff[NUM_W-2:0], fits};
            r_ff   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = n_ff;
   assign rem  = r_ff;

endmodule

>>> hdl/atc_checker.sv
// Port-level checks for the audio transport clock, bound to the top level.
// Depends on atc_pkg and audio_transport_clock_macros.svh.
`include "audio_transport_clock_macros.svh"

module atc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [atc_pkg::QW-1:0]         rsp_sample_position,
   input logic [atc_pkg::QW-1:0]         rsp_tick_position,
   input logic [atc_pkg::BAR_W-1:0]      rsp_bar_number,
   input logic [atc_pkg::BEAT_W-1:0]     rsp_beat_number
);

   // An accepted command keeps the block busy on the next cycle.
   `ATC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accepting a command")

   // Bar and beat are either both reported or both zero.
   `ATC_ASSERT_NOW(a_bar_beat_pair, clock, reset, rsp_valid, (rsp_bar_number == '0) == (rsp_beat_number == '0), "bar and beat disagree on zero")

   // Zero samples can never convert to a nonzero tick count.
   `ATC_ASSERT_NOW(a_ticks_need_samples, clock, reset, rsp_valid && (rsp_tick_position != '0), rsp_sample_position != '0, "ticks without samples")

   // A stalled result holds.
   `ATC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_position) && $stable(rsp_bar_number), "stalled result changed")

endmodule

bind audio_transport_clock atc_checker u_atc_checker (.*);

>>> dv/tb_audio_transport_clock.sv
`timescale 1ns / 100ps
// Self-checking testbench for audio_transport_clock: commands and register settings
// against a built-in transport model. Depends on atc_pkg and the block itself.
module tb_audio_transport_clock;
   import atc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int          RANDOM_PHASES = 12;
   localparam int          CMDS_PER_PHASE = 150;
   localparam int          SETTLE_CYCLES = 400;   // long enough for one full command to finish
   localparam int          PRINT_CAP = 50;

   // One command beat as the sender presents it.
   typedef struct {
      logic [CMD_W-1:0]   command;
      logic [NSAMP_W-1:0] num_samples;
      logic [QW-1:0]      query_ticks;
   } transport_cmd_type;

   // One result beat as the transport should report it.
   typedef struct {
      logic [QW-1:0]     samples;
      logic [QW-1:0]     ticks;
      logic [BAR_W-1:0]  bar;
      logic [BEAT_W-1:0] beat_num;
      logic              running;
   } position_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = '0;
   logic [NSAMP_W-1:0]    req_num_samples = '0;
   logic [QW-1:0]         req_query_ticks = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [QW-1:0]         rsp_sample_position;
   logic [QW-1:0]         rsp_tick_position;
   logic [BAR_W-1:0]      rsp_bar_number;
   logic [BEAT_W-1:0]     rsp_beat_number;
   logic                  rsp_is_running;

   audio_transport_clock dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_num_samples     (req_num_samples),
      .req_query_ticks     (req_query_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample_position (rsp_sample_position),
      .rsp_tick_position   (rsp_tick_position),
      .rsp_bar_number      (rsp_bar_number),
      .rsp_beat_number     (rsp_beat_number),
      .rsp_is_running      (rsp_is_running)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Transport model: its own copy of the registers and the position state.
   // ------------------------------------------------------------------
   logic [RATE_W-1:0]        cfg_rate = RATE_RST;
   logic [BPM_W-1:0]         cfg_bpm  = BPM_RST;
   logic [TPQ_W-1:0]         cfg_tpq  = TPQ_RST;
   logic [BPB_W-1:0]         cfg_bpb  = BPB_RST;
   logic [NOTE_W-1:0]        cfg_note = NOTE_RST;
   logic [POSITION_BITS-1:0] model_samples = '0;
   logic                     model_running = 1'b0;

   transport_cmd_type pending_commands[$];
   position_type      expected_positions[$];

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int mismatch_count = 0;
   int accepted_cmds = 0;
   int results_checked = 0;
   int settings_used = 0;
   int bar_limit_seen = 0;
   int zeroed_seen = 0;
   int unsigned cycle_count = 0;
   logic req_fire = 1'b0;

   // A zero in any of these disables every conversion.
   function automatic logic settings_valid();
      return cfg_rate != 0 && cfg_bpm != 0 && cfg_tpq != 0 && cfg_note != 0;
   endfunction

   // Ticks for a sample count, floor-rounded and saturating.
   function automatic logic [QW-1:0] ticks_for(input logic [POSITION_BITS-1:0] count);
      logic [127:0] quo;
      if (!settings_valid())
         return '0;
      quo = (128'(count) * cfg_tpq * cfg_bpm) / (128'(cfg_rate) * 60);
      return (quo > 128'(POS_MAX)) ? QW'(POS_MAX) : quo[QW-1:0];
   endfunction

   // Convert ticks back to samples, then split into bar and beat number.
   function automatic void locate_bar(input logic [QW-1:0] t, output logic [BAR_W-1:0] bar,
                                      output logic [BEAT_W-1:0] beat_num);
      logic [127:0] spb, bar_len, spos, nbar, rem;
      bar = '0;
      beat_num = '0;
      if (!settings_valid())
         return;
      spb = (128'(cfg_rate) * 60 * cfg_note) / (128'(cfg_bpm) * 4);
      // a beat shorter than one sample, or an empty bar, reports nothing
      if (spb == 0 || cfg_bpb == 0)
         return;
      bar_len = spb * cfg_bpb;
      spos = (128'(t) * 60 * cfg_rate) / (128'(cfg_tpq) * cfg_bpm);
      nbar = spos / bar_len;
      rem = spos % bar_len;
      bar = (nbar >= 128'(BAR_MAX)) ? BAR_MAX : BAR_W'(nbar + 1);
      beat_num = BEAT_W'(rem / spb + 1);
   endfunction

   // Apply one command to the model and return the result it should cause.
   function automatic position_type transport_step(input transport_cmd_type c);
      position_type p;
      logic [POSITION_BITS:0] sum;
      case (c.command)
         CMD_ADVANCE: begin
            // advance only moves a running transport; saturate at the top
            if (model_running) begin
               sum = {1'b0, model_samples} + (POSITION_BITS + 1)'(c.num_samples);
               model_samples = sum[POSITION_BITS] ? POS_MAX : sum[POSITION_BITS-1:0];
            end
         end
         CMD_START: model_running = 1'b1;
         CMD_STOP:  model_running = 1'b0;
         CMD_CLEAR: model_samples = '0;   // run flag is kept
         default: ;                       // query and unused codes change nothing
      endcase
      p.samples = QW'(model_samples);
      p.ticks = ticks_for(model_samples);
      locate_bar((c.command == CMD_QUERY) ? c.query_ticks : p.ticks, p.bar, p.beat_num);
      p.running = model_running;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[cycle %0d] %s: got %0h, want %0h", cycle_count, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Driver: present command beats at the falling edge, hold until taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_cmds
      transport_cmd_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // advance only once the current beat has been taken
         if (!req_valid || req_fire) begin
            if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd = pending_commands.pop_front();
               req_valid <= 1'b1;
               req_command <= next_cmd.command;
               req_num_samples <= next_cmd.num_samples;
               req_query_ticks <= next_cmd.query_ticks;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted command, check each accepted result.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      transport_cmd_type seen;
      position_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            seen.command = req_command;
            seen.num_samples = req_num_samples;
            seen.query_ticks = req_query_ticks;
            expected_positions.push_back(transport_step(seen));
            accepted_cmds++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_positions.size() == 0) begin
               report_mismatch("result beat with no command outstanding",
                               64'(rsp_sample_position), 64'd0);
            end else begin
               want = expected_positions.pop_front();
               if (rsp_sample_position !== want.samples)
                  report_mismatch("sample_position", 64'(rsp_sample_position),
                                  64'(want.samples));
               if (rsp_tick_position !== want.ticks)
                  report_mismatch("tick_position", 64'(rsp_tick_position), 64'(want.ticks));
               if (rsp_bar_number !== want.bar)
                  report_mismatch("bar_number", 64'(rsp_bar_number), 64'(want.bar));
               if (rsp_beat_number !== want.beat_num)
                  report_mismatch("beat_number", 64'(rsp_beat_number), 64'(want.beat_num));
               if (rsp_is_running !== want.running)
                  report_mismatch("is_running", 64'(rsp_is_running), 64'(want.running));
               results_checked++;
               if (want.bar == BAR_MAX)
                  bar_limit_seen++;
               if (want.bar == '0)
                  zeroed_seen++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out with %0d commands queued, %0d results outstanding",
                  pending_commands.size(), expected_positions.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_cmd(input logic [CMD_W-1:0] command, input logic [NSAMP_W-1:0] n,
                            input logic [QW-1:0] q);
      transport_cmd_type c;
      c.command = command;
      c.num_samples = n;
      c.query_ticks = q;
      pending_commands.push_back(c);
   endtask

   // Advances are the most common command, with queries across all magnitudes.
   task automatic queue_random_cmd();
      logic [CMD_W-1:0]   command;
      logic [NSAMP_W-1:0] n;
      logic [63:0]        q;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 45)      command = CMD_ADVANCE;
      else if (pick < 55) command = CMD_START;
      else if (pick < 63) command = CMD_STOP;
      else if (pick < 68) command = CMD_CLEAR;
      else if (pick < 93) command = CMD_QUERY;
      else                command = CMD_QUERY + CMD_W'($urandom_range(1, 3));
      case ($urandom_range(9))
         0:       n = '0;
         1:       n = '1;
         2, 3, 4: n = NSAMP_W'($urandom_range(1, 256));
         default: n = NSAMP_W'($urandom_range(65535));
      endcase
      case ($urandom_range(9))
         0:       q = '0;
         1:       q = '1;
         default: q = {$urandom(), $urandom()} >> $urandom_range(47);
      endcase
      queue_cmd(command, n, q[QW-1:0]);
   endtask

   // Write one register at the falling edge, drop the enable at the next one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLE_RATE: cfg_rate = data[RATE_W-1:0];
         CSR_TEMPO_BPM:   cfg_bpm  = data[BPM_W-1:0];
         CSR_TPQ:         cfg_tpq  = data[TPQ_W-1:0];
         CSR_BEATS_BAR:   cfg_bpb  = data[BPB_W-1:0];
         CSR_BEAT_NOTE:   cfg_note = data[NOTE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic musical_setting(output logic [CSR_DATA_W-1:0] rate, bpm, tpq, bpb, note);
      case ($urandom_range(6))
         0:       rate = CSR_DATA_W'(8000);
         1:       rate = CSR_DATA_W'(22050);
         2:       rate = CSR_DATA_W'(44100);
         3:       rate = CSR_DATA_W'(48000);
         4:       rate = CSR_DATA_W'(96000);
         5:       rate = CSR_DATA_W'(192000);
         default: rate = CSR_DATA_W'(384000);
      endcase
      bpm = CSR_DATA_W'($urandom_range(40, 240));
      case ($urandom_range(5))
         0:       tpq = CSR_DATA_W'(24);
         1:       tpq = CSR_DATA_W'(96);
         2:       tpq = CSR_DATA_W'(192);
         3:       tpq = CSR_DATA_W'(480);
         4:       tpq = CSR_DATA_W'(960);
         default: tpq = CSR_DATA_W'($urandom_range(1, 65535));
      endcase
      bpb = CSR_DATA_W'($urandom_range(1, 16));
      note = CSR_DATA_W'(1) << $urandom_range(5);
   endtask

   // Pick the register values for one phase and write all of them.
   task automatic program_phase(input int phase);
      logic [CSR_DATA_W-1:0] rate, bpm, tpq, bpb, note;
      case (phase)
         0: begin
            // every register at its widest value
            rate = '1; bpm = '1; tpq = '1; bpb = '1; note = '1;
         end
         1: begin
            rate = CSR_DATA_W'(1); bpm = CSR_DATA_W'(1); tpq = CSR_DATA_W'(1);
            bpb = CSR_DATA_W'(1); note = CSR_DATA_W'(1);
         end
         2: begin
            // beat length rounds down to no samples at all
            rate = CSR_DATA_W'(1); bpm = CSR_DATA_W'(999); tpq = CSR_DATA_W'(480);
            bpb = CSR_DATA_W'(4); note = CSR_DATA_W'(1);
         end
         3: begin
            rate = CSR_DATA_W'(48000); bpm = CSR_DATA_W'(120); tpq = CSR_DATA_W'(960);
            bpb = '0; note = CSR_DATA_W'(4);
         end
         4: begin
            // one conversion setting at zero
            musical_setting(rate, bpm, tpq, bpb, note);
            case ($urandom_range(3))
               0:       rate = '0;
               1:       bpm = '0;
               2:       tpq = '0;
               default: note = '0;
            endcase
         end
         default: begin
            if ($urandom_range(1) == 0) begin
               musical_setting(rate, bpm, tpq, bpb, note);
            end else begin
               // raw data, upper bits included, so the register masking is exercised
               rate = CSR_DATA_W'($urandom_range(19'h7FFFF));
               bpm = CSR_DATA_W'($urandom_range(19'h7FFFF));
               tpq = CSR_DATA_W'($urandom_range(19'h7FFFF));
               bpb = CSR_DATA_W'($urandom_range(19'h7FFFF));
               note = CSR_DATA_W'($urandom_range(19'h7FFFF));
            end
         end
      endcase
      write_csr(CSR_SAMPLE_RATE, rate);
      write_csr(CSR_TEMPO_BPM, bpm);
      write_csr(CSR_TPQ, tpq);
      write_csr(CSR_BEATS_BAR, bpb);
      write_csr(CSR_BEAT_NOTE, note);
      // an index past the last register must change nothing
      if ($urandom_range(2) == 0)
         write_csr(CSR_BEAT_NOTE + CSR_IDX_W'($urandom_range(1, 3)),
                   CSR_DATA_W'($urandom_range(19'h7FFFF)));
      settings_used++;
   endtask

   // Hold until every queued command is taken and every result is back.
   task automatic drain();
      while (pending_commands.size() != 0 || req_valid || expected_positions.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed commands on the reset settings, sender 24 / receiver 64 idle.
      send_idle_pct = 24;
      take_idle_pct = 64;
      settings_used = 1;
      queue_cmd(CMD_QUERY, '0, '0);
      queue_cmd(CMD_ADVANCE, '1, '0);           // stopped: counter holds
      queue_cmd(CMD_START, '0, '0);
      queue_cmd(CMD_ADVANCE, '1, '0);
      queue_cmd(CMD_ADVANCE, '0, '1);
      queue_cmd(CMD_ADVANCE, 16'd1, '0);
      queue_cmd(CMD_QUERY, '0, '1);             // largest tick position
      queue_cmd(CMD_QUERY, '1, 48'd1);
      queue_cmd(CMD_QUERY, '0, 48'd1920);       // first tick of bar two
      queue_cmd(CMD_QUERY + 3'd1, '1, '1);      // unused codes report as a stopped advance
      queue_cmd(CMD_QUERY + 3'd2, 16'h5A5A, 48'hA5A5_A5A5_A5A5);
      queue_cmd(CMD_QUERY + 3'd3, '1, '0);
      queue_cmd(CMD_CLEAR, '1, '1);             // clear while running keeps the run flag
      queue_cmd(CMD_ADVANCE, 16'd48000, '0);
      queue_cmd(CMD_STOP, '0, '0);
      queue_cmd(CMD_ADVANCE, 16'd12345, '0);
      queue_cmd(CMD_CLEAR, '0, '0);
      queue_cmd(CMD_START, '0, '0);
      queue_cmd(CMD_START, '0, '0);
      queue_cmd(CMD_ADVANCE, '1, '0);
      queue_cmd(CMD_STOP, '0, '0);
      queue_cmd(CMD_STOP, '0, '0);
      drain();

      // Random phases: each starts from a fresh register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < RANDOM_PHASES / 3) begin
            send_idle_pct = 24;
            take_idle_pct = 64;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 64;
            take_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         program_phase(phase);
         // open most phases on a running transport so advances move the counter
         if ($urandom_range(3) != 0)
            queue_cmd(CMD_START, NSAMP_W'($urandom()), QW'({$urandom(), $urandom()}));
         repeat (CMDS_PER_PHASE) queue_random_cmd();
         drain();
      end

      // Let any stray result beat show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_positions.size() != 0)
         report_mismatch("results never delivered", 64'(expected_positions.size()), 64'd0);

      $display("%0d commands over %0d register settings, %0d results checked",
               accepted_cmds, settings_used, results_checked);
      $display("%0d results at the bar limit, %0d with bar and beat zeroed, %0d mismatches",
               bar_limit_seen, zeroed_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/atc_pkg.sv
hdl/atc_div.sv
hdl/audio_transport_clock.sv
hdl/atc_checker.sv
dv/tb_audio_transport_clock.sv
